/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DWTS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dwts assertion failed");

// Expression must never be true outside reset.
`define DWTS_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("dwts forbidden condition seen");

`endif

/* rtl/dwts_pkg.sv */
package dwts_pkg;

  localparam logic [31:0] SyncMask = 32'hC0F0_0000;
  localparam logic [31:0] Sync48   = 32'h8040_0000;
  localparam logic [31:0] Sync63   = 32'h8050_0000;

  // Word class from bits 31:30.
  localparam logic [1:0] TopUnknown = 2'b00;
  localparam logic [1:0] TopWave    = 2'b01;
  localparam logic [1:0] TopInfo    = 2'b10;
  localparam logic [1:0] TopAdc     = 2'b11;

  typedef enum logic [2:0] {
    KIND_ADC     = 3'd0,
    KIND_VERNIER = 3'd1,
    KIND_INFO    = 3'd2,
    KIND_WAVE    = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_DATA      = 2'd0,
    PH_TIME      = 2'd1,
    PH_MARK_MID  = 2'd2,
    PH_MARK_TIME = 2'd3
  } phase_e;

  typedef struct packed {
    logic [31:0] in_word;
    logic        block_start;
  } in_item_t;

  typedef struct packed {
    logic [63:0] timestamp;
    logic [31:0] raw_word;
    logic [27:0] time_lo;
    kind_e       kind;
    logic [6:0]  module_number;
    logic [5:0]  channel;
    logic [15:0] payload;
    logic        veto;
    logic [3:0]  info_code;
    logic [19:0] info_field;
  } out_item_t;

  // Split one data word into its fields, stamped with the running time.
  function automatic out_item_t dwts_decode(input logic [31:0] w,
                                            input logic [27:0] lt,
                                            input logic [63:0] ts);
    out_item_t r;
    r               = '0;
    r.timestamp     = {ts[63:28], lt};
    r.raw_word      = w;
    r.time_lo       = lt;
    r.kind          = KIND_UNKNOWN;
    case (w[31:30])
      TopAdc: begin
        r.module_number = 7'(w[27:22]) + 7'd1;
        r.channel       = w[21:16];
        r.payload       = w[15:0];
        r.kind          = w[29] ? KIND_VERNIER : KIND_ADC;
        r.veto          = w[28];
      end
      TopWave: begin
        r.module_number = 7'(w[27:22]) + 7'd1;
        r.channel       = w[21:16];
        r.payload       = w[15:0];
        r.kind          = KIND_WAVE;
      end
      TopInfo: begin
        r.kind          = KIND_INFO;
        r.module_number = 7'(w[29:24]) + 7'd1;
        r.info_code     = w[23:20];
        r.info_field    = w[19:0];
      end
      TopUnknown: begin
        r.kind = KIND_UNKNOWN;
      end
      default: begin
        r.kind = KIND_UNKNOWN;
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/dwts_core.sv */
`include "assert_macros.svh"

module dwts_core
  import dwts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  logic      sync_en_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  phase_e      phase_q, phase_d;
  logic [14:0] skip_q, skip_d;
  logic [31:0] held_word_q, held_word_d;
  logic [31:0] held_marker_q, held_marker_d;
  logic [63:0] ts_q, ts_d;

  phase_e      eff_phase;
  logic [14:0] eff_skip;
  logic [27:0] lt;
  logic        is_sync63;
  logic        is_sync48;
  logic        skip_step;
  logic        first_step;
  logic        mark_close;

  // A block start drops any half-formed pair, marker or skip.
  assign eff_phase = item_i.block_start ? PH_DATA : phase_q;
  assign eff_skip  = item_i.block_start ? 15'd0 : skip_q;
  assign lt        = item_i.in_word[27:0];
  assign is_sync63 = (held_word_q & SyncMask) == Sync63;
  assign is_sync48 = (held_word_q & SyncMask) == Sync48;

  // Next state.
  always_comb begin
    phase_d       = phase_q;
    skip_d        = skip_q;
    held_word_d   = held_word_q;
    held_marker_d = held_marker_q;
    ts_d          = ts_q;
    if (step_i) begin
      phase_d = eff_phase;
      skip_d  = eff_skip;
      if (eff_skip != 15'd0) begin
        skip_d = eff_skip - 15'd1;
      end else begin
        case (eff_phase)
          PH_DATA: begin
            held_word_d = item_i.in_word;
            phase_d     = PH_TIME;
          end
          PH_TIME: begin
            phase_d = PH_DATA;
            if (is_sync63) begin
              phase_d = PH_MARK_MID;
            end else if (is_sync48) begin
              ts_d = {ts_q[63:48], held_word_q[19:0], lt};
            end else if (held_word_q[31:30] == TopWave) begin
              skip_d = held_word_q[15:1];
            end
          end
          PH_MARK_MID: begin
            held_marker_d = item_i.in_word;
            phase_d       = PH_MARK_TIME;
          end
          PH_MARK_TIME: begin
            ts_d    = {held_word_q[15:0], held_marker_q[19:0], lt};
            phase_d = PH_DATA;
          end
          default: begin
            phase_d = PH_DATA;
          end
        endcase
      end
    end
  end

  // Outputs.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = dwts_decode(held_word_q, lt, ts_q);
    if (step_i && (eff_skip == 15'd0)) begin
      case (eff_phase)
        PH_TIME: begin
          res_valid_o = (is_sync63 || is_sync48) ? sync_en_i : 1'b1;
        end
        PH_MARK_TIME: begin
          res_o       = dwts_decode(held_marker_q, lt, ts_q);
          res_valid_o = sync_en_i;
        end
        PH_DATA, PH_MARK_MID: begin
          res_valid_o = 1'b0;
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_DATA;
      skip_q        <= '0;
      held_word_q   <= '0;
      held_marker_q <= '0;
      ts_q          <= '0;
    end else begin
      phase_q       <= phase_d;
      skip_q        <= skip_d;
      held_word_q   <= held_word_d;
      held_marker_q <= held_marker_d;
      ts_q          <= ts_d;
    end
  end

  assign skip_step  = step_i && (eff_skip != 15'd0);
  assign first_step = step_i && ((eff_phase == PH_DATA) || (eff_phase == PH_MARK_MID));
  assign mark_close = step_i && (eff_skip == 15'd0) && (eff_phase == PH_MARK_TIME);

  `DWTS_NEVER(a_no_res_in_skip, clk_i, rst_ni, skip_step && res_valid_o)
  `DWTS_NEVER(a_no_res_on_data, clk_i, rst_ni, first_step && res_valid_o)
  `DWTS_ASSERT(a_marker_sets_ts, clk_i, rst_ni, mark_close |=> ts_q[27:0] == $past(lt))
  `DWTS_ASSERT(a_marker_ends, clk_i, rst_ni, mark_close |=> phase_q == PH_DATA)

endmodule

/* rtl/daq_word_timestamp_decoder_top.sv */
// Readout word decoder with a running 64-bit timestamp.
// Input channel: in_valid_i / in_stall_o carry one raw 32-bit word and a
// block start flag per transfer. Words pair up as data word plus time word;
// each completed pair yields at most one decoded result on the output
// channel out_valid_o / out_stall_i. Sample words after a waveform header
// and the first word of every pair yield no result.
// Configuration: cfg_we_i writes cfg_wdata_i into the sync output enable;
// write it only while the block is idle.
// A result is loaded into the result register when its word advances out of
// the input register. Throughput: one word per cycle while no stall holds the
// result register; the single decode stage sits between the two registers.
// Stall: the result register holds its transfer while out_stall_i is high;
// at most one further input word is taken into the input register, then
// in_stall_o rises until the result is taken.
// Reset: clears the pairing phase, skip count, timestamp, the enable and
// both valid flags.
module daq_word_timestamp_decoder_top
  import dwts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      sync_en_q;

  logic      in_xfer;
  logic      advance;
  logic      res_valid;
  out_item_t res;

  // Advance the held word whenever the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  dwts_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .sync_en_i   (sync_en_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sync_en_q   <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        sync_en_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

/* tb/daq_word_timestamp_decoder_top_test.sv */
module daq_word_timestamp_decoder_top_test;
  import dwts_pkg::*;

  // Directed stimulus row. Where typed is set, exp_item is the result read off by hand
  // and replaces the decoder prediction for that word.
  typedef struct {
    logic [31:0] word;
    logic        start;
    bit          typed;
    out_item_t   exp_item;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;
  logic      cfg_we_i;
  logic      cfg_wdata_i;

  // Decoder state as this bench tracks it.
  logic        sync_en;
  phase_e      pair_state;
  logic [31:0] pair_word;
  logic [31:0] marker_word;
  logic [63:0] stamp_now;
  logic [14:0] samples_left;

  out_item_t awaited_results[$];
  int        bad_fields;

  // Idle control for both channels. The final phase turns both off.
  bit gaps_on;
  int gap_odds;
  bit stall_on;

  dir_row_t steps [0:23];

  daq_word_timestamp_decoder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Split one word into result fields, stamped with the current upper timestamp bits.
  function automatic out_item_t word_fields(input logic [31:0] w, input logic [27:0] lt);
    out_item_t r;
    r           = '0;
    r.timestamp = {stamp_now[63:28], lt};
    r.raw_word  = w;
    r.time_lo   = lt;
    r.kind      = KIND_UNKNOWN;
    if (w[30]) begin
      // Top bits 11 (adc / vernier) and 01 (waveform header) share the layout.
      r.module_number = {1'b0, w[27:22]} + 7'd1;
      r.channel       = w[21:16];
      r.payload       = w[15:0];
      if (w[31]) begin
        r.kind = w[29] ? KIND_VERNIER : KIND_ADC;
        r.veto = w[28];
      end else begin
        r.kind = KIND_WAVE;
      end
    end else if (w[31]) begin
      r.kind          = KIND_INFO;
      r.module_number = {1'b0, w[29:24]} + 7'd1;
      r.info_code     = w[23:20];
      r.info_field    = w[19:0];
    end
    return r;
  endfunction

  // Advance the tracked decoder by one accepted word; return 1 when it yields a result.
  function automatic bit advance_decoder(input logic [31:0] w, input logic st,
                                         output out_item_t r);
    logic [27:0] lt;
    bit          got;
    lt  = w[27:0];
    got = 1'b0;
    r   = '0;
    // Block start drops any half-formed pair or marker and the skip; keep the timestamp.
    if (st) begin
      pair_state   = PH_DATA;
      samples_left = '0;
    end
    if (samples_left != 0) begin
      samples_left = samples_left - 15'd1;
      return 1'b0;
    end
    case (pair_state)
      PH_DATA: begin
        pair_word  = w;
        pair_state = PH_TIME;
      end
      PH_TIME: begin
        pair_state = PH_DATA;
        if ((pair_word & SyncMask) == Sync63) begin
          // First pair of a marker: report with this pair's time, then collect the rest.
          got        = sync_en;
          r          = word_fields(pair_word, lt);
          pair_state = PH_MARK_MID;
        end else if ((pair_word & SyncMask) == Sync48) begin
          got       = sync_en;
          r         = word_fields(pair_word, lt);
          stamp_now = {stamp_now[63:48], pair_word[19:0], lt};
        end else begin
          got = 1'b1;
          r   = word_fields(pair_word, lt);
          // Waveform header: skip length/2 sample words, rounded down.
          if (pair_word[31:30] == TopWave) samples_left = pair_word[15:1];
        end
      end
      PH_MARK_MID: begin
        marker_word = w;
        pair_state  = PH_MARK_TIME;
      end
      default: begin
        // Marker close: report the middle word with the old upper timestamp bits, then reload it all.
        // Info field bits above 15 fall off the top.
        got        = sync_en;
        r          = word_fields(marker_word, lt);
        stamp_now  = {pair_word[15:0], marker_word[19:0], lt};
        pair_state = PH_DATA;
      end
    endcase
    return got;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] e, input logic [63:0] a);
    bad_fields++;
    if (bad_fields <= 10) $display("%s: expected %h, got %h", what, e, a);
  endtask

  // Offer one word, hold it until the transfer, then record what it should yield.
  task automatic send_word(input logic [31:0] w, input logic st, input bit typed = 1'b0,
                           input out_item_t typed_item = '0);
    out_item_t predicted;
    if (gaps_on && $urandom_range(0, gap_odds) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= in_item_t'{in_word: w, block_start: st};
    do @(posedge clk_i); while (in_stall_o);
    if (advance_decoder(w, st, predicted))
      awaited_results.push_back(typed ? typed_item : predicted);
  endtask

  // Drop valid and let every awaited result drain, plus margin for the word still
  // held in the block and for a word that yields nothing.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sync_enable(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sync_en = v;
    cfg_we_i    <= 1'b0;
  endtask

  // Emit one well-formed sequence with random content, or a broken one, or noise.
  task automatic send_sequence(ref int words, input bit huge_wave);
    logic [31:0] rnd;
    logic [31:0] rnd2;
    logic [15:0] len;
    int          roll;
    roll = $urandom_range(0, 99);
    rnd  = $urandom();
    rnd2 = $urandom();
    if (huge_wave) begin
      // Longest possible skip (32767 sample words), cut short by a block start.
      send_word({TopWave, rnd[13:0], 16'hFFFF}, 1'b0);
      send_word(rnd2, 1'b0);
      for (int i = 0; i < 6; i++) send_word($urandom(), 1'b0);
      send_word({TopAdc, rnd[29:0]}, 1'b1);
      send_word($urandom(), 1'b0);
      words += 10;
    end else if (roll < 30) begin
      send_word({TopAdc, rnd[29:0]}, $urandom_range(0, 29) == 0);
      send_word(rnd2, $urandom_range(0, 29) == 0);
      words += 2;
    end else if (roll < 45) begin
      send_word({TopInfo, rnd[29:0]}, $urandom_range(0, 29) == 0);
      send_word(rnd2, $urandom_range(0, 29) == 0);
      words += 2;
    end else if (roll < 57) begin
      send_word({TopInfo, rnd[29:24], 4'd4, rnd[19:0]}, $urandom_range(0, 29) == 0);
      send_word(rnd2, $urandom_range(0, 29) == 0);
      words += 2;
    end else if (roll < 67) begin
      send_word({TopInfo, rnd[29:24], 4'd5, rnd[19:0]}, $urandom_range(0, 29) == 0);
      send_word(rnd2, $urandom_range(0, 29) == 0);
      send_word($urandom(), $urandom_range(0, 29) == 0);
      send_word($urandom(), $urandom_range(0, 29) == 0);
      words += 4;
    end else if (roll < 80) begin
      len = 16'($urandom_range(0, 40));
      send_word({TopWave, rnd[29:16], len}, $urandom_range(0, 29) == 0);
      send_word(rnd2, $urandom_range(0, 29) == 0);
      for (int i = 0; i < len / 2; i++) send_word($urandom(), $urandom_range(0, 39) == 0);
      words += 2 + int'(len[15:1]);
    end else if (roll < 87) begin
      send_word({TopUnknown, rnd[29:0]}, $urandom_range(0, 29) == 0);
      send_word(rnd2, $urandom_range(0, 29) == 0);
      words += 2;
    end else begin
      // Lone word to knock the pairing out of step; keep any waveform length short.
      if (rnd[31:30] == TopWave) rnd[15:7] = '0;
      send_word(rnd, rnd2[0]);
      words += 1;
    end
  endtask

  // Compare each transfer on the result channel with the oldest awaited result.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result, raw_word", 64'd0, 64'(out_data_o.raw_word));
      end else begin
        e = awaited_results.pop_front();
        if (out_data_o.timestamp !== e.timestamp)
          note_mismatch("timestamp", e.timestamp, out_data_o.timestamp);
        if (out_data_o.raw_word !== e.raw_word)
          note_mismatch("raw_word", 64'(e.raw_word), 64'(out_data_o.raw_word));
        if (out_data_o.time_lo !== e.time_lo)
          note_mismatch("time_lo", 64'(e.time_lo), 64'(out_data_o.time_lo));
        if (out_data_o.kind !== e.kind)
          note_mismatch("kind", 64'(e.kind), 64'(out_data_o.kind));
        if (out_data_o.module_number !== e.module_number)
          note_mismatch("module_number", 64'(e.module_number), 64'(out_data_o.module_number));
        if (out_data_o.channel !== e.channel)
          note_mismatch("channel", 64'(e.channel), 64'(out_data_o.channel));
        if (out_data_o.payload !== e.payload)
          note_mismatch("payload", 64'(e.payload), 64'(out_data_o.payload));
        if (out_data_o.veto !== e.veto)
          note_mismatch("veto", 64'(e.veto), 64'(out_data_o.veto));
        if (out_data_o.info_code !== e.info_code)
          note_mismatch("info_code", 64'(e.info_code), 64'(out_data_o.info_code));
        if (out_data_o.info_field !== e.info_field)
          note_mismatch("info_field", 64'(e.info_field), 64'(out_data_o.info_field));
      end
    end
  end

  // Stall the result channel in bursts, with free stretches in between.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (stall_on && $urandom_range(0, 2) != 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Hard stop for a hung handshake or lost results.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int words;
    bit long_done;
    bit huge;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= 1'b0;
    sync_en      = 1'b0;
    pair_state   = PH_DATA;
    pair_word    = '0;
    marker_word  = '0;
    stamp_now    = '0;
    samples_left = '0;
    bad_fields   = 0;
    gaps_on      = 1'b1;
    gap_odds     = 4;
    stall_on     = 1'b1;
    long_done    = 1'b0;

    steps = '{
      // All ones pair right after reset: vernier, top module, veto set, upper timestamp bits zero.
      '{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, '{64'h0FFF_FFFF, 32'hFFFF_FFFF, 28'hFFF_FFFF,
        KIND_VERNIER, 7'd64, 6'd63, 16'hFFFF, 1'b1, 4'd0, 20'd0}},
      // All zeros pair: unknown word, every field zero.
      '{32'h0000_0000, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 1'b0, 1'b1, '{64'd0, 32'd0, 28'd0,
        KIND_UNKNOWN, 7'd0, 6'd0, 16'd0, 1'b0, 4'd0, 20'd0}},
      // Info word with every field at its top value.
      '{32'hBFFF_FFFF, 1'b0, 1'b0, '0},
      '{32'h8000_0001, 1'b0, 1'b1, '{64'd1, 32'hBFFF_FFFF, 28'd1,
        KIND_INFO, 7'd64, 6'd0, 16'd0, 1'b0, 4'hF, 20'hF_FFFF}},
      // Code-4 sync, then an adc word stamped with the new upper bits.
      '{32'h8041_2345, 1'b0, 1'b0, '0},
      '{32'h0ABC_DEF0, 1'b0, 1'b0, '0},
      '{32'hD0AB_1234, 1'b0, 1'b0, '0},
      '{32'hF000_0005, 1'b0, 1'b0, '0},
      // Code-5 marker with wide info field; middle word looks like a waveform but skips nothing.
      '{32'h805F_FFFF, 1'b0, 1'b0, '0},
      '{32'h0000_0010, 1'b0, 1'b0, '0},
      '{32'h400F_FFFF, 1'b0, 1'b0, '0},
      '{32'h0FFF_FFFE, 1'b0, 1'b0, '0},
      // Odd waveform length 3 skips one sample word that looks like a sync word.
      '{32'h4000_0003, 1'b0, 1'b0, '0},
      '{32'h0000_0001, 1'b0, 1'b0, '0},
      '{32'h8040_0000, 1'b0, 1'b0, '0},
      // Block start in the middle of a skip, then in the middle of a pair.
      '{32'h4000_0008, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 1'b0, 1'b0, '0},
      '{32'h0000_0001, 1'b1, 1'b0, '0},
      '{32'h805A_AAAA, 1'b1, 1'b0, '0},
      '{32'h0000_0003, 1'b0, 1'b0, '0},
      // Block start in the middle of a marker.
      '{32'h1234_5678, 1'b1, 1'b0, '0},
      '{32'h0000_0004, 1'b0, 1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_sync_enable(1'b1);
    for (int i = 0; i < 24; i++)
      send_word(steps[i].word, steps[i].start, steps[i].typed, steps[i].exp_item);

    // Random phases, alternating the enable; the last one runs without any idling.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_sync_enable(ph[0]);
      gap_odds = $urandom_range(2, 8);
      if (ph == 3) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      words = 0;
      while (words < 110) begin
        huge = (ph == 1) && (words >= 50) && !long_done;
        send_sequence(words, huge);
        long_done = long_done || huge;
      end
    end

    drain();
    if (bad_fields == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* daq_word_timestamp_decoder_top.f */
+incdir+rtl
rtl/dwts_pkg.sv
rtl/dwts_core.sv
rtl/daq_word_timestamp_decoder_top.sv
tb/daq_word_timestamp_decoder_top_test.sv
